// ----- hdl/lcdnw_pkg.sv -----
package lcdnw_pkg;

   // defaults for the top-level parameters
   localparam int LINE_CHARS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // character count, fixed 6-bit field
   localparam int                 COUNT_W   = 6;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // operation codes on req_op
   localparam int             OP_W          = 3;
   localparam logic [OP_W-1:0] OP_PUT_CHAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_RAW_CMD   = 3'd1;
   localparam logic [OP_W-1:0] OP_RAW_DATA  = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
   localparam logic [OP_W-1:0] OP_SET_POS   = 3'd4;
   localparam logic [OP_W-1:0] OP_SET_STATE = 3'd5;
   localparam logic [OP_W-1:0] OP_INIT      = 3'd6;

   // display commands
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] CMD_INIT_DISPLAY = 8'h0E;
   localparam logic [7:0] CMD_LINE1        = 8'h80;
   localparam logic [7:0] CMD_LINE2        = 8'hC0;

   // single nibbles of the 4-bit bus setup
   localparam logic [3:0] NIB_FUNC_HI = 4'h2;
   localparam logic [3:0] NIB_FUNC_LO = 4'h8;

   // strobe sequence kinds queued between front and back
   localparam int               KIND_W          = 3;
   localparam logic [KIND_W-1:0] KIND_BYTE       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LINE2_DATA = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR_DATA = 3'd3;
   localparam logic [KIND_W-1:0] KIND_INIT       = 3'd4;

   // strobe index within one sequence
   localparam int               STEP_W         = 4;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd10;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              rs;
      logic [7:0]        data;
   } job_type;

   typedef struct packed {
      logic       rs;
      logic [3:0] nib;
      logic       last;
   } strobe_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // byte number of the final byte in a paired sequence
   function automatic logic [STEP_W-2:0] last_pos(logic [KIND_W-1:0] kind);
      logic [STEP_W-2:0] p;
      case (kind)
         KIND_LINE2_DATA: p = 3'd1;
         KIND_CLEAR:      p = 3'd1;
         KIND_CLEAR_DATA: p = 3'd2;
         default:         p = 3'd0;
      endcase
      return p;
   endfunction

   // byte sent at byte number pos of a paired sequence
   function automatic logic [7:0] seq_byte(job_type j, logic [STEP_W-2:0] pos);
      logic [7:0] b;
      case (j.kind)
         KIND_LINE2_DATA: b = pos[0] ? j.data : CMD_LINE2;
         KIND_CLEAR:      b = pos[0] ? CMD_LINE1 : CMD_CLEAR;
         KIND_CLEAR_DATA: b = pos[1] ? j.data : (pos[0] ? CMD_LINE1 : CMD_CLEAR);
         default:         b = j.data;
      endcase
      return b;
   endfunction

   // power-up sequence, one nibble per strobe
   function automatic logic [3:0] init_nibble(logic [STEP_W-1:0] step);
      logic [3:0] n;
      case (step)
         4'd0:    n = NIB_FUNC_HI;
         4'd1:    n = NIB_FUNC_HI;
         4'd2:    n = NIB_FUNC_LO;
         4'd3:    n = CMD_INIT_DISPLAY[7:4];
         4'd4:    n = CMD_INIT_DISPLAY[3:0];
         4'd5:    n = CMD_CLEAR[7:4];
         4'd6:    n = CMD_CLEAR[3:0];
         4'd7:    n = CMD_LINE1[7:4];
         4'd8:    n = CMD_LINE1[3:0];
         4'd9:    n = CMD_ENTRY_MODE[7:4];
         default: n = CMD_ENTRY_MODE[3:0];
      endcase
      return n;
   endfunction

   function automatic strobe_type job_strobe(job_type j, logic [STEP_W-1:0] step);
      strobe_type        s;
      logic [STEP_W-2:0] pos;
      logic [STEP_W-2:0] lp;
      logic [7:0]        b;
      pos = step[STEP_W-1:1];
      lp  = last_pos(j.kind);
      b   = seq_byte(j, pos);
      if (j.kind == KIND_INIT) begin
         s.rs   = 1'b0;
         s.nib  = init_nibble(step);
         s.last = (step == INIT_LAST_STEP);
      end else begin
         s.rs   = (pos == lp) ? j.rs : 1'b0;
         s.nib  = step[0] ? b[3:0] : b[7:4];
         s.last = step[0] && (pos == lp);
      end
      return s;
   endfunction

endpackage

// ----- hdl/lcdnw_front.sv -----
module lcdnw_front #(
   parameter int LINE_CHARS = lcdnw_pkg::LINE_CHARS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [lcdnw_pkg::OP_W-1:0]     req_op,
   input  logic [7:0]                     req_value,
   input  logic [5:0]                     req_column,
   input  logic                           req_row,
   input  logic                           req_display_on,
   input  logic                           req_cursor_on,
   input  logic                           req_blink_on,
   input  logic                           queue_full,
   output logic                           push,
   output lcdnw_pkg::job_type             push_job
);
   import lcdnw_pkg::*;

   localparam int WRAP_LIMIT = (2 * LINE_CHARS > 63) ? 63 : 2 * LINE_CHARS;
   localparam logic [COUNT_W-1:0] LINE_COUNT = COUNT_W'(LINE_CHARS);
   localparam logic [COUNT_W-1:0] WRAP_COUNT = COUNT_W'(WRAP_LIMIT);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] count_inc;
   logic               accept;
   logic               known_op;

   assign accept    = req_valid && !queue_full;
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);

   always_comb begin
      push_job.kind = KIND_BYTE;
      push_job.rs   = 1'b0;
      push_job.data = req_value;
      known_op      = 1'b1;
      count_in      = count_ff;
      case (req_op)
         OP_PUT_CHAR: begin
            push_job.rs = 1'b1;
            if (count_ff == LINE_COUNT) begin
               push_job.kind = KIND_LINE2_DATA;
               count_in      = count_inc;
            end else if (count_ff >= WRAP_COUNT) begin
               push_job.kind = KIND_CLEAR_DATA;
               count_in      = COUNT_W'(1);
            end else begin
               count_in = count_inc;
            end
         end
         OP_RAW_CMD: begin
            push_job.rs = 1'b0;
         end
         OP_RAW_DATA: begin
            push_job.rs = 1'b1;
         end
         OP_CLEAR: begin
            push_job.kind = KIND_CLEAR;
            count_in      = '0;
         end
         OP_SET_POS: begin
            push_job.data = {1'b1, req_row, req_column};
         end
         OP_SET_STATE: begin
            push_job.data = req_display_on
                          ? (CMD_DISPLAY_ON | {6'b0, req_cursor_on, req_blink_on})
                          : CMD_DISPLAY_OFF;
         end
         OP_INIT: begin
            push_job.kind = KIND_INIT;
            count_in      = '0;
         end
         default: begin
            known_op = 1'b0;
         end
      endcase
   end

   assign push = accept && known_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- hdl/lcdnw_queue.sv -----
module lcdnw_queue #(
   parameter int DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  lcdnw_pkg::job_type            push_job,
   input  logic                          pop,
   output lcdnw_pkg::job_type            head_job,
   output lcdnw_pkg::queue_status_type   status
);
   import lcdnw_pkg::*;

   // pointers wrap after the last entry, any depth works
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   job_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   assign head_job     = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/lcdnw_back.sv -----
module lcdnw_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  lcdnw_pkg::job_type  head_job,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_reg_select,
   output logic [3:0]          rsp_nibble,
   output logic                rsp_last
);
   import lcdnw_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   strobe_type        strobe_ff, strobe_in;
   strobe_type        strobe;
   logic              advance;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign strobe  = job_strobe(head_job, step_ff);
   assign pop     = advance && head_valid && strobe.last;

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      strobe_in    = strobe_ff;
      if (advance) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            strobe_in = strobe;
            step_in   = strobe.last ? '0 : step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      strobe_ff <= strobe_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_select = strobe_ff.rs;
   assign rsp_nibble     = strobe_ff.nib;
   assign rsp_last       = strobe_ff.last;

endmodule

// ----- hdl/char_lcd_nibble_writer.sv -----
// Character display writer for a two-line display on a 4-bit bus. Each request is one operation
// (put char, raw command, raw data, clear, set position, set display state, init) and turns
// into a run of nibble strobes on the rsp side, high nibble first, each with its register-select
// bit and with rsp_last marking the final strobe of the request. The back end sends one strobe
// per cycle while rsp_stall is low, so a request is 2 strobes (raw byte, position, state, plain
// put char), 4 strobes (clear, put char that moves to line two), 6 strobes (put char that wraps
// and clears first) or 11 strobes (init); unused op code 7 is taken and produces nothing.
// Requests are classified on entry and wait in a QUEUE_DEPTH-entry queue, so a new request is
// taken every cycle until that queue fills; req_stall is high exactly while it is full.
module char_lcd_nibble_writer #(
   parameter int LINE_CHARS  = lcdnw_pkg::LINE_CHARS_DEFAULT,
   parameter int QUEUE_DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lcdnw_pkg::OP_W-1:0]  req_op,
   input  logic [7:0]                  req_value,
   input  logic [5:0]                  req_column,
   input  logic                        req_row,
   input  logic                        req_display_on,
   input  logic                        req_cursor_on,
   input  logic                        req_blink_on,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_reg_select,
   output logic [3:0]                  rsp_nibble,
   output logic                        rsp_last
);
   import lcdnw_pkg::*;

   // front to queue
   logic             push;
   job_type          push_job;

   // queue to back
   job_type          head_job;
   logic             pop;
   queue_status_type q_status;

   // front: decodes the op, keeps the character count, picks the strobe sequence
   lcdnw_front #(
      .LINE_CHARS (LINE_CHARS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_op         (req_op),
      .req_value      (req_value),
      .req_column     (req_column),
      .req_row        (req_row),
      .req_display_on (req_display_on),
      .req_cursor_on  (req_cursor_on),
      .req_blink_on   (req_blink_on),
      .queue_full     (q_status.full),
      .push           (push),
      .push_job       (push_job)
   );

   // sequences waiting for the back end
   lcdnw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // back: steps through the head sequence, one strobe per transfer
   lcdnw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (!q_status.empty),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_select (rsp_reg_select),
      .rsp_nibble     (rsp_nibble),
      .rsp_last       (rsp_last)
   );

   // stall only on a full queue, never on the op itself
   assign req_stall = q_status.full;

   // an empty queue always takes a transfer
   a_empty_not_stalled: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !req_stall)
      else $error("request stalled with an empty queue");

   // a real op that is taken leaves work in the queue
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall
       && (req_op == OP_PUT_CHAR || req_op == OP_RAW_CMD || req_op == OP_RAW_DATA
           || req_op == OP_CLEAR || req_op == OP_SET_POS || req_op == OP_SET_STATE
           || req_op == OP_INIT)) |=> !q_status.empty)
      else $error("accepted operation did not reach the queue");

   // the output register is never dropped while stalled
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(rsp_valid)) |-> $past(!rsp_stall))
      else $error("strobe dropped without a transfer");

   // output register is empty right after reset
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("strobe pending after reset");

endmodule
